[src/tbp_pkg.sv]
package tbp_pkg;

   // Default coordinate width, signed Q16.16 at 32 bits.
   localparam int COORD_WIDTH_DEF = 32;

   // Result format: signed Q8.24.
   localparam int OUT_W    = 32;
   localparam int OUT_FRAC = 24;

   // Multipliers are built from signed partial products of this many bits per operand chunk.
   localparam int MUL_CHUNK = 24;
   localparam int MUL_LAT   = 3;

   // Divider: one setup stage, one stage per quotient bit, one output stage.
   localparam int DIV_LAT = OUT_W + 2;

endpackage

[src/tbp_mul.sv]
module tbp_mul #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [A_W-1:0]     a,
   input  logic signed [B_W-1:0]     b,
   output logic signed [A_W+B_W-1:0] p
);
   import tbp_pkg::*;

   localparam int K   = MUL_CHUNK;
   localparam int NA  = (A_W + K - 1) / K;
   localparam int NB  = (B_W + K - 1) / K;
   localparam int PW  = A_W + B_W;
   localparam int PPW = 2 * K + 2;

   logic signed [NA*K-1:0] a_ext;
   logic signed [NB*K-1:0] b_ext;
   logic signed [PPW-1:0]  pp_in [NA][NB];
   logic signed [PPW-1:0]  pp_ff [NA][NB];
   logic [PW-1:0]          row_in [NA];
   logic [PW-1:0]          row_ff [NA];
   logic [PW-1:0]          p_in;
   logic [PW-1:0]          p_ff;

   assign a_ext = (NA*K)'(a);
   assign b_ext = (NB*K)'(b);

   // Lower chunks are unsigned, the top chunk carries the sign.
   always_comb begin
      logic signed [K:0] ca;
      logic signed [K:0] cb;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            ca = (i == NA - 1) ? {a_ext[K*i+K-1], a_ext[K*i +: K]} : {1'b0, a_ext[K*i +: K]};
            cb = (j == NB - 1) ? {b_ext[K*j+K-1], b_ext[K*j +: K]} : {1'b0, b_ext[K*j +: K]};
            pp_in[i][j] = ca * cb;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (K * j));
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         p_in = p_in + (row_ff[i] << (K * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[src/tbp_div.sv]
module tbp_div #(
   parameter int MAG_W = 139,
   parameter int DEN_W = 139
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic [MAG_W-1:0]                 mag,
   input  logic                             neg,
   input  logic [DEN_W-1:0]                 den,
   output logic signed [tbp_pkg::OUT_W-1:0] quo
);
   import tbp_pkg::*;

   localparam int SH    = OUT_FRAC + 1;
   localparam int MW    = ((MAG_W + SH > DEN_W) ? MAG_W + SH : DEN_W) + 1;
   localparam int EW    = DEN_W + 1;
   localparam int CW    = (MW > EW + OUT_W) ? MW : EW + OUT_W;
   localparam int STEPS = OUT_W;

   logic [CW-1:0]    m_in;
   logic [EW-1:0]    e_in;
   logic             big_in;
   logic [CW-1:0]    rem_ff [STEPS];
   logic [EW-1:0]    e_ff   [STEPS];
   logic [OUT_W-1:0] q_ff   [STEPS+1];
   logic             neg_ff [STEPS+1];
   logic             big_ff [STEPS+1];
   logic [OUT_W-1:0] bound;
   logic [OUT_W-1:0] mag_fin;
   logic [OUT_W-1:0] quo_ff;

   // Rounded magnitude is floor((mag * 2^25 + den) / (2 * den)); anything at or above
   // 2^32 saturates whatever the quotient bits are, and so does anything past the signed bound.
   assign m_in   = CW'({mag, {SH{1'b0}}}) + CW'(den);
   assign e_in   = {den, 1'b0};
   assign big_in = m_in >= (CW'(e_in) << STEPS);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= m_in;
         e_ff[0]   <= e_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         big_ff[0] <= big_in;
      end
   end

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [CW-1:0] sub;
      logic          ge;
      assign sub = CW'(e_ff[s]) << (STEPS - 1 - s);
      assign ge  = rem_ff[s] >= sub;
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s+1]   <= {q_ff[s][OUT_W-2:0], ge};
            neg_ff[s+1] <= neg_ff[s];
            big_ff[s+1] <= big_ff[s];
         end
      end
      if (s < STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s+1] <= ge ? rem_ff[s] - sub : rem_ff[s];
               e_ff[s+1]   <= e_ff[s];
            end
         end
      end
   end

   assign bound   = neg_ff[STEPS] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
   assign mag_fin = (big_ff[STEPS] || (q_ff[STEPS] > bound)) ? bound : q_ff[STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[STEPS] ? (~mag_fin + OUT_W'(1)) : mag_fin;
      end
   end

   assign quo = quo_ff;

endmodule

[src/triangle_barycentric_projection_unit.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_point_{x,y,z}, req_corner_{a,b,c}_{x,y,z}
// rsp       out        rsp_valid/rsp_stall   rsp_weight_a, rsp_weight_b, rsp_weight_c
//
// One transaction enters per cycle while req_stall is low. At the default widths the pipeline
// holds 46 register stages (1 + 2 * MUL_LAT + 1 + 4 + DIV_LAT), the last of which drives
// the rsp ports. The restoring divider makes up most of that depth.
// Reset is synchronous and clears only the valid bits that travel with each stage.
// A result held under rsp_stall freezes the whole pipeline and raises req_stall in the same
// cycle; nothing is dropped or repeated.
module triangle_barycentric_projection_unit #(
   parameter int COORD_WIDTH = tbp_pkg::COORD_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [COORD_WIDTH-1:0]    req_point_x,
   input  logic signed [COORD_WIDTH-1:0]    req_point_y,
   input  logic signed [COORD_WIDTH-1:0]    req_point_z,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_a_x,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_a_y,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_a_z,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_b_x,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_b_y,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_b_z,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_c_x,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_c_y,
   input  logic signed [COORD_WIDTH-1:0]    req_corner_c_z,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_a,
   output logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_b,
   output logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_c
);
   import tbp_pkg::*;

   // Edge vectors, dot products, second-level products and the three numerators.
   localparam int DW   = COORD_WIDTH + 1;
   localparam int DOTW = 2 * DW + 2;
   localparam int PW2  = 2 * DOTW;
   localparam int NW   = PW2 + 1;
   localparam int N3W  = NW + 2;
   localparam int LAT  = 1 + MUL_LAT + 1 + MUL_LAT + 4 + DIV_LAT;

   // Dot product slots: u.u, u.v, v.v, u.w, v.w.
   localparam int NDOT   = 5;
   localparam int DOT_UU = 0;
   localparam int DOT_UV = 1;
   localparam int DOT_VV = 2;
   localparam int DOT_UW = 3;
   localparam int DOT_VW = 4;
   localparam int NPROD  = 6;

   logic           en;
   logic [LAT-1:0] vld_ff;

   // The whole pipeline advances unless a finished result is being held.
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // Edge vectors u = a - c, v = b - c and the offset w = p - c.
   logic signed [DW-1:0] u_ff [3];
   logic signed [DW-1:0] v_ff [3];
   logic signed [DW-1:0] w_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff[0] <= DW'(req_corner_a_x) - DW'(req_corner_c_x);
         u_ff[1] <= DW'(req_corner_a_y) - DW'(req_corner_c_y);
         u_ff[2] <= DW'(req_corner_a_z) - DW'(req_corner_c_z);
         v_ff[0] <= DW'(req_corner_b_x) - DW'(req_corner_c_x);
         v_ff[1] <= DW'(req_corner_b_y) - DW'(req_corner_c_y);
         v_ff[2] <= DW'(req_corner_b_z) - DW'(req_corner_c_z);
         w_ff[0] <= DW'(req_point_x) - DW'(req_corner_c_x);
         w_ff[1] <= DW'(req_point_y) - DW'(req_corner_c_y);
         w_ff[2] <= DW'(req_point_z) - DW'(req_corner_c_z);
      end
   end

   // Fifteen coordinate products feed the five dot products.
   logic signed [DW-1:0]   m1a [NDOT][3];
   logic signed [DW-1:0]   m1b [NDOT][3];
   logic signed [2*DW-1:0] m1p [NDOT][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         m1a[DOT_UU][j] = u_ff[j];
         m1b[DOT_UU][j] = u_ff[j];
         m1a[DOT_UV][j] = u_ff[j];
         m1b[DOT_UV][j] = v_ff[j];
         m1a[DOT_VV][j] = v_ff[j];
         m1b[DOT_VV][j] = v_ff[j];
         m1a[DOT_UW][j] = u_ff[j];
         m1b[DOT_UW][j] = w_ff[j];
         m1a[DOT_VW][j] = v_ff[j];
         m1b[DOT_VW][j] = w_ff[j];
      end
   end

   for (genvar k = 0; k < NDOT; k++) begin : g_dot
      for (genvar j = 0; j < 3; j++) begin : g_axis
         tbp_mul #(.A_W(DW), .B_W(DW)) u_mul (
            .clock (clock),
            .en    (en),
            .a     (m1a[k][j]),
            .b     (m1b[k][j]),
            .p     (m1p[k][j])
         );
      end
   end

   logic signed [DOTW-1:0] dot_ff [NDOT];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NDOT; k++) begin
            dot_ff[k] <= DOTW'(m1p[k][0]) + DOTW'(m1p[k][1]) + DOTW'(m1p[k][2]);
         end
      end
   end

   // Cramer's rule on the Gram system: det = uu*vv - uv*uv, n1 = uw*vv - uv*vw,
   // n2 = uu*vw - uv*uw. Products come in pairs that are subtracted.
   logic signed [DOTW-1:0] m2a [NPROD];
   logic signed [DOTW-1:0] m2b [NPROD];
   logic signed [PW2-1:0]  m2p [NPROD];

   always_comb begin
      m2a[0] = dot_ff[DOT_UU];
      m2b[0] = dot_ff[DOT_VV];
      m2a[1] = dot_ff[DOT_UV];
      m2b[1] = dot_ff[DOT_UV];
      m2a[2] = dot_ff[DOT_UW];
      m2b[2] = dot_ff[DOT_VV];
      m2a[3] = dot_ff[DOT_UV];
      m2b[3] = dot_ff[DOT_VW];
      m2a[4] = dot_ff[DOT_UU];
      m2b[4] = dot_ff[DOT_VW];
      m2a[5] = dot_ff[DOT_UV];
      m2b[5] = dot_ff[DOT_UW];
   end

   for (genvar k = 0; k < NPROD; k++) begin : g_prod
      tbp_mul #(.A_W(DOTW), .B_W(DOTW)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (m2a[k]),
         .b     (m2b[k]),
         .p     (m2p[k])
      );
   end

   // The dot products ride alongside the multipliers for the degenerate cases.
   logic signed [DOTW-1:0] dly_ff [MUL_LAT][NDOT];

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= dot_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   logic signed [NW-1:0]   det_a_ff;
   logic signed [NW-1:0]   n1_a_ff;
   logic signed [NW-1:0]   n2_a_ff;
   logic signed [DOTW-1:0] dot_a_ff [NDOT];

   always_ff @(posedge clock) begin
      if (en) begin
         det_a_ff <= NW'(m2p[0]) - NW'(m2p[1]);
         n1_a_ff  <= NW'(m2p[2]) - NW'(m2p[3]);
         n2_a_ff  <= NW'(m2p[4]) - NW'(m2p[5]);
         dot_a_ff <= dly_ff[MUL_LAT-1];
      end
   end

   // A zero-length first edge or collinear corners fall back to a projection onto one edge;
   // with all corners equal the whole weight goes to the third corner.
   logic signed [NW-1:0] q_b_in;
   logic signed [NW-1:0] n1_b_in;
   logic signed [NW-1:0] n2_b_in;
   logic signed [NW-1:0] q_b_ff;
   logic signed [NW-1:0] n1_b_ff;
   logic signed [NW-1:0] n2_b_ff;

   always_comb begin
      if (dot_a_ff[DOT_UU] != '0) begin
         if (det_a_ff != '0) begin
            q_b_in  = det_a_ff;
            n1_b_in = n1_a_ff;
            n2_b_in = n2_a_ff;
         end else begin
            q_b_in  = NW'(dot_a_ff[DOT_UU]);
            n1_b_in = NW'(dot_a_ff[DOT_UW]);
            n2_b_in = '0;
         end
      end else if (dot_a_ff[DOT_VV] != '0) begin
         q_b_in  = NW'(dot_a_ff[DOT_VV]);
         n1_b_in = '0;
         n2_b_in = NW'(dot_a_ff[DOT_VW]);
      end else begin
         q_b_in  = NW'(1);
         n1_b_in = '0;
         n2_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_b_ff  <= q_b_in;
         n1_b_ff <= n1_b_in;
         n2_b_ff <= n2_b_in;
      end
   end

   // The third numerator comes from the exact numerators, before any rounding.
   logic signed [N3W-1:0] q_c_ff;
   logic signed [N3W-1:0] n_c_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         q_c_ff    <= N3W'(q_b_ff);
         n_c_ff[0] <= N3W'(n1_b_ff);
         n_c_ff[1] <= N3W'(n2_b_ff);
         n_c_ff[2] <= N3W'(q_b_ff) - N3W'(n1_b_ff) - N3W'(n2_b_ff);
      end
   end

   // Sign and magnitude for the dividers; the denominator is never negative.
   logic [N3W-1:0] den_d_ff;
   logic [N3W-1:0] mag_d_ff [3];
   logic           neg_d_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         den_d_ff <= q_c_ff;
         for (int k = 0; k < 3; k++) begin
            neg_d_ff[k] <= n_c_ff[k][N3W-1];
            mag_d_ff[k] <= n_c_ff[k][N3W-1] ? (~n_c_ff[k] + N3W'(1)) : n_c_ff[k];
         end
      end
   end

   logic signed [OUT_W-1:0] quo [3];

   for (genvar k = 0; k < 3; k++) begin : g_div
      tbp_div #(.MAG_W(N3W), .DEN_W(N3W)) u_div (
         .clock (clock),
         .en    (en),
         .mag   (mag_d_ff[k]),
         .neg   (neg_d_ff[k]),
         .den   (den_d_ff),
         .quo   (quo[k])
      );
   end

   assign rsp_weight_a = quo[0];
   assign rsp_weight_b = quo[1];
   assign rsp_weight_c = quo[2];

endmodule

[src/tbp_check.sv]
module tbp_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_a,
   input logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_b,
   input logic signed [tbp_pkg::OUT_W-1:0] rsp_weight_c
);
   import tbp_pkg::*;

   // A held result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A held result keeps its weights.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_weight_a) && $stable(rsp_weight_b)
                                 && $stable(rsp_weight_c))
      else $error("result changed while stalled");

   // The input side backs off exactly when a finished result is held.
   a_req_stall: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output back-pressure");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind triangle_barycentric_projection_unit tbp_check u_tbp_check (.*);

[tb/triangle_barycentric_projection_unit_tb.sv]
`timescale 1ns / 1ps

module triangle_barycentric_projection_unit_tb;
   import tbp_pkg::*;

   localparam int CW          = COORD_WIDTH_DEF;
   localparam int PIPE_DEPTH  = 46;
   localparam int IDLE_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 1100;

   // Wide signed arithmetic: products of dot products need more than 128 bits.
   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      logic signed [CW-1:0] px, py, pz;
      logic signed [CW-1:0] ax, ay, az;
      logic signed [CW-1:0] bx, by, bz;
      logic signed [CW-1:0] cx, cy, cz;
   } query_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] wa, wb, wc;
   } weights_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   query_type drive_q = '0;
   logic signed [OUT_W-1:0] rsp_weight_a, rsp_weight_b, rsp_weight_c;

   weights_type expected_weights[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   triangle_barycentric_projection_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(drive_q.px), .req_point_y(drive_q.py), .req_point_z(drive_q.pz),
      .req_corner_a_x(drive_q.ax), .req_corner_a_y(drive_q.ay), .req_corner_a_z(drive_q.az),
      .req_corner_b_x(drive_q.bx), .req_corner_b_y(drive_q.by), .req_corner_b_z(drive_q.bz),
      .req_corner_c_x(drive_q.cx), .req_corner_c_y(drive_q.cy), .req_corner_c_z(drive_q.cz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_weight_a(rsp_weight_a), .rsp_weight_b(rsp_weight_b), .rsp_weight_c(rsp_weight_c)
   );

   // Rounds n/q to Q8.24, to nearest with ties away from zero, then saturates.
   // The denominator q is always positive here.
   function automatic logic signed [OUT_W-1:0] round_to_q824(wide_type n, wide_type q);
      logic neg;
      wide_type mag;
      neg = n[255];
      mag = neg ? -n : n;
      mag = ((mag << (OUT_FRAC + 1)) + q) / (q << 1);
      if (neg) begin
         if (mag > 256'h80000000) mag = 256'h80000000;
         return -mag[OUT_W-1:0];
      end
      if (mag > 256'h7FFFFFFF) mag = 256'h7FFFFFFF;
      return mag[OUT_W-1:0];
   endfunction

   // Projects the point onto the triangle's plane and solves the Gram system by
   // Cramer's rule, with the degenerate edge and collinear cases handled exactly.
   function automatic weights_type project_weights(query_type t);
      wide_type u[3], v[3], w[3];
      wide_type uu, uv, vv, uw, vw, det, q, n1, n2;
      weights_type r;
      u[0] = wide_type'(t.ax) - wide_type'(t.cx);
      u[1] = wide_type'(t.ay) - wide_type'(t.cy);
      u[2] = wide_type'(t.az) - wide_type'(t.cz);
      v[0] = wide_type'(t.bx) - wide_type'(t.cx);
      v[1] = wide_type'(t.by) - wide_type'(t.cy);
      v[2] = wide_type'(t.bz) - wide_type'(t.cz);
      w[0] = wide_type'(t.px) - wide_type'(t.cx);
      w[1] = wide_type'(t.py) - wide_type'(t.cy);
      w[2] = wide_type'(t.pz) - wide_type'(t.cz);
      uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
      uv = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
      vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      uw = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
      vw = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
      if (uu != 0) begin
         det = uu*vv - uv*uv;
         if (det != 0) begin
            q = det;
            n1 = uw*vv - uv*vw;
            n2 = uu*vw - uv*uw;
         end else begin
            // Collinear corners: the second weight drops out.
            q = uu; n1 = uw; n2 = 0;
         end
      end else if (vv != 0) begin
         // The first edge has zero length.
         q = vv; n1 = 0; n2 = vw;
      end else begin
         // All three corners coincide.
         q = 1; n1 = 0; n2 = 0;
      end
      r.wa = round_to_q824(n1, q);
      r.wb = round_to_q824(n2, q);
      r.wc = round_to_q824(q - n1 - n2, q);
      return r;
   endfunction

   // Offers one query at the falling edge and holds it until the block takes it.
   // The prediction is queued at the accepting edge, so it always precedes the result.
   task automatic send_query(query_type t);
      @(negedge clock);
      drive_q   <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_weights.insert(expected_weights.size(), project_weights(t));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Sends in bursts; back-to-back items keep valid high across the burst.
   task automatic send_burst(query_type items[$]);
      foreach (items[i]) begin
         if (i == 0) @(negedge clock);
         drive_q   <= items[i];
         req_valid <= 1'b1;
         do @(posedge clock); while (req_stall);
         expected_weights.insert(expected_weights.size(), project_weights(items[i]));
         @(negedge clock);
      end
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [CW-1:0] random_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
         2: return $signed($urandom_range(0, 32'h0FFFFF)) - 32'sh080000;
         default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      endcase
   endfunction

   function automatic query_type random_query();
      query_type t;
      int mode, shape;
      mode  = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 5 ? 1 : 2);
      if ($urandom_range(0, 19) == 0) mode = 3;
      t = {random_coord(mode), random_coord(mode), random_coord(mode),
           random_coord(mode), random_coord(mode), random_coord(mode),
           random_coord(mode), random_coord(mode), random_coord(mode),
           random_coord(mode), random_coord(mode), random_coord(mode)};
      shape = $urandom_range(0, 19);
      // Now and then force a degenerate triangle so those paths see random data too.
      if (shape == 0) {t.ax, t.ay, t.az} = {t.cx, t.cy, t.cz};
      else if (shape == 1) {t.bx, t.by, t.bz} = {t.cx, t.cy, t.cz};
      else if (shape == 2) begin
         {t.ax, t.ay, t.az} = {t.cx, t.cy, t.cz};
         {t.bx, t.by, t.bz} = {t.cx, t.cy, t.cz};
      end else if (shape == 3) begin
         // b lies on the line through c and a, at twice the distance.
         t.bx = 2*t.ax - t.cx; t.by = 2*t.ay - t.cy; t.bz = 2*t.az - t.cz;
      end
      return t;
   endfunction

   task automatic test_directed();
      query_type t;
      query_type burst[$];
      // Unit right triangle with the point at each corner and above the centroid.
      t = '0;
      t.ax = 32'sh10000; t.by = 32'sh10000;
      burst.insert(burst.size(), t);
      t.px = 32'sh10000; burst.insert(burst.size(), t);
      t.px = 0; t.py = 32'sh10000; burst.insert(burst.size(), t);
      t.px = 32'sh5555; t.py = 32'sh5555; t.pz = 32'sh7FFFFFFF; burst.insert(burst.size(), t);
      // Point far outside the triangle drives weights into saturation.
      t.px = 32'sh7FFFFFFF; t.py = 32'sh80000000; t.pz = 0; burst.insert(burst.size(), t);
      t.ax = 1; t.by = 1; t.px = 32'sh7FFFFFFF; t.py = 32'sh7FFFFFFF;
      burst.insert(burst.size(), t);
      // Zero-length first edge.
      t = '0; t.bx = 32'sh30000; t.px = 32'sh10000; t.py = 32'sh7000;
      burst.insert(burst.size(), t);
      // Collinear corners with a nonzero first edge.
      t = '0; t.ax = 32'sh10000; t.bx = 32'sh20000; t.px = 32'sh8000; t.pz = -5;
      burst.insert(burst.size(), t);
      // All corners equal, at zero and at both coordinate extremes.
      t = '0; t.px = 32'sh12345678; burst.insert(burst.size(), t);
      t = {12{32'sh80000000}}; burst.insert(burst.size(), t);
      t = {12{32'sh7FFFFFFF}}; burst.insert(burst.size(), t);
      // Extreme corners with the widest differences the fields allow, then mixed bit patterns.
      t = {32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
           32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
           32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
           32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
      burst.insert(burst.size(), t);
      t = {12{32'shFFFFFFFF}}; t.ax = 0; t.by = 32'sh55555555; burst.insert(burst.size(), t);
      t = {12{32'shAAAAAAAA}}; t.bx = 32'sh55555555; t.cz = 1; burst.insert(burst.size(), t);
      t = {12{32'sh55555555}}; t.ay = 32'shAAAAAAAA; t.pz = -1; burst.insert(burst.size(), t);
      send_burst(burst);
      send_query(random_query());
   endtask

   // Random bursts of random length separated by random gaps; some long
   // stretches go back to back.
   task automatic test_random(int count);
      query_type burst[$];
      int len;
      while (count > 0) begin
         len = $urandom_range(1, 24);
         if (len > count) len = count;
         burst.delete();
         repeat (len) burst.insert(burst.size(), random_query());
         send_burst(burst);
         count -= len;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering,
   // so the pipeline fills and backs up onto req_stall.
   task automatic test_backpressure();
      query_type burst[$];
      hold_off = 1'b1;
      repeat (3 * PIPE_DEPTH) burst.insert(burst.size(), random_query());
      send_burst(burst);
      wait (!hold_off);
   endtask

   // Receiver stall pattern: a long hold while hold_off is set, else quiet periods alternate with random stalling.
   always @(negedge clock) begin : stall_pattern
      int phase;
      int hold_count;
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_count++;
         if (hold_count >= 200) begin
            hold_off   = 1'b0;
            hold_count = 0;
         end
      end else begin
         phase = int'(($time / 2000) % 3);
         if (phase == 0) rsp_stall <= 1'b0;
         else if (phase == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // Compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      weights_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_weight_a, rsp_weight_b, rsp_weight_c};
         if (expected_weights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result a=%h b=%h c=%h", got.wa, got.wb, got.wc);
         end else begin
            want = expected_weights.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Weight mismatch: expected a=%h b=%h c=%h, got a=%h b=%h c=%h",
                           want.wa, want.wb, want.wc, got.wa, got.wb, got.wc);
            end
         end
      end
   end

   // Watchdog: ends the run once nothing has been accepted for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(RANDOM_ITEMS);
      wait (expected_weights.size() == 0);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatches == 0 && expected_weights.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
